>>> sv/canvas_shape_rasterizer_unit_defines.svh
// assertion macros used by the checker
`ifndef CANVAS_SHAPE_RASTERIZER_UNIT_DEFINES_SVH
`define CANVAS_SHAPE_RASTERIZER_UNIT_DEFINES_SVH

// property checked at every edge, reset included
`define CSR_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("check failed");

// property checked only outside reset
`define CSR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");

`endif

>>> sv/csr_pkg.sv
// shared types and constants of the shape rasterizer
`timescale 1ns / 1ps
package csr_pkg;

  // coordinate width, wide enough for origin plus extent
  localparam int CW = 18;

  // command codes
  localparam logic [3:0] K_POINT = 4'd0;
  localparam logic [3:0] K_LINE  = 4'd1;
  localparam logic [3:0] K_RECT  = 4'd2;
  localparam logic [3:0] K_RFILL = 4'd3;
  localparam logic [3:0] K_CIRC  = 4'd4;
  localparam logic [3:0] K_CFILL = 4'd5;
  localparam logic [3:0] K_COLOR = 4'd6;
  localparam logic [3:0] K_CLEAR = 4'd7;
  localparam logic [3:0] K_OVL   = 4'd8;

  // memory word: drawn flag over rgb, cleared to white and undrawn
  localparam logic [24:0] CLEAR_WORD = 25'h0FFFFFF;

  // one run of pixels along a row (horiz) or a column
  typedef struct packed {
    logic                 horiz;
    logic signed [CW-1:0] fixed;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi;
  } span_t;

  typedef enum logic [1:0] {
    SP_IDLE,
    SP_CHK,
    SP_RUN
  } sp_state_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_POINT,
    S_LSET,
    S_LINE,
    S_RECT,
    S_RFSET,
    S_RFILL,
    S_CSQ,
    S_CKGO,
    S_CKW,
    S_CI,
    S_CJGO,
    S_CJW,
    S_COUT,
    S_OVL,
    S_OVLD,
    S_WAIT,
    S_RESP
  } seq_state_t;

endpackage

>>> sv/csr_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module csr_ram #(
  parameter int WIDTH  = 25,
  parameter int DEPTH  = 76800,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/csr_isqrt.sv
// iterative integer square root of a 32-bit value, giving a 16-bit root
`timescale 1ns / 1ps
module csr_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] val,
  output logic        done,
  output logic [15:0] root
);

  logic [31:0] v_r, v_nxt;
  logic [31:0] res_r, res_nxt;
  logic [31:0] bit_r, bit_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [31:0] trial;

  // one digit step of the remainder and root
  always_comb begin
    trial    = res_r + bit_r;
    v_nxt    = v_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      v_nxt   = val;
      res_nxt = '0;
      bit_nxt = 32'h4000_0000;
      cnt_nxt = 5'd16;
    end else if (cnt_r != 5'd0) begin
      if (v_r >= trial) begin
        v_nxt   = v_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt  = bit_r >> 2;
      cnt_nxt  = cnt_r - 5'd1;
      done_nxt = (cnt_r == 5'd1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[15:0];

endmodule

>>> sv/csr_span.sv
// clipped span walker, writes one pixel per cycle into the canvas memory
`timescale 1ns / 1ps
module csr_span
  import csr_pkg::*;
#(
  parameter int CANVAS_WIDTH  = 320,
  parameter int CANVAS_HEIGHT = 240,
  parameter int ADDR_W        = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  span_t             cmd,
  input  logic [23:0]       pen,
  output logic              idle,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [24:0]       wr_data
);

  localparam logic signed [CW-1:0] W_S = CW'(CANVAS_WIDTH);
  localparam logic signed [CW-1:0] H_S = CW'(CANVAS_HEIGHT);

  sp_state_t            st_r, st_nxt;
  span_t                c_r;
  logic signed [CW-1:0] cur_r, cur_nxt;
  logic signed [CW-1:0] end_r, end_nxt;
  logic signed [CW-1:0] flim, rlim, lo_c, hi_c, px, py;
  logic                 fix_ok;

  // clip limits of the latched span
  always_comb begin
    flim   = c_r.horiz ? H_S : W_S;
    rlim   = c_r.horiz ? W_S : H_S;
    lo_c   = (c_r.lo < 0) ? '0 : c_r.lo;
    hi_c   = (c_r.hi > rlim - 1) ? rlim - 1 : c_r.hi;
    fix_ok = (c_r.fixed >= 0) && (c_r.fixed < flim);
  end

  // next state
  always_comb begin
    st_nxt  = st_r;
    cur_nxt = cur_r;
    end_nxt = end_r;
    unique case (st_r)
      SP_IDLE: begin
        if (go) begin
          st_nxt = SP_CHK;
        end
      end
      SP_CHK: begin
        cur_nxt = lo_c;
        end_nxt = hi_c;
        st_nxt  = (fix_ok && (lo_c <= hi_c)) ? SP_RUN : SP_IDLE;
      end
      SP_RUN: begin
        if (cur_r == end_r) begin
          st_nxt = SP_IDLE;
        end else begin
          cur_nxt = cur_r + 1'b1;
        end
      end
      default: st_nxt = SP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SP_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // span payload
  always_ff @(posedge clk) begin
    if (st_r == SP_IDLE && go) begin
      c_r <= cmd;
    end
    cur_r <= cur_nxt;
    end_r <= end_nxt;
  end

  // pixel address row times width plus column
  always_comb begin
    px = c_r.horiz ? cur_r : c_r.fixed;
    py = c_r.horiz ? c_r.fixed : cur_r;
  end

  assign idle    = (st_r == SP_IDLE);
  assign wr_en   = (st_r == SP_RUN);
  assign wr_addr = ADDR_W'(ADDR_W'(py) * ADDR_W'(CANVAS_WIDTH) + ADDR_W'(px));
  assign wr_data = {1'b1, pen};

endmodule

>>> sv/canvas_shape_rasterizer_unit.sv
// Shape rasterizer top: command sequencer over span walker, sqrt unit and canvas memory.
// Drawing writes pixels through the span walker, one span or line point at a time;
// circles also run the square root unit for each step of i.
// Point draws a single-pixel span, overlay does one memory read, clear rewrites the whole canvas.
// Reset runs a clearing pass over all W*H words (76800 at 320x240) with in_ready low.
// One command in flight; its result waits in an output register while the next command can be taken.
`timescale 1ns / 1ps
module canvas_shape_rasterizer_unit
  import csr_pkg::*;
#(
  parameter int CANVAS_WIDTH  = 320,
  parameter int CANVAS_HEIGHT = 240
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_kind,
  input  logic signed [15:0] in_arg_a,
  input  logic signed [15:0] in_arg_b,
  input  logic signed [15:0] in_arg_c,
  input  logic signed [15:0] in_arg_d,
  input  logic [7:0]         in_base_red,
  input  logic [7:0]         in_base_green,
  input  logic [7:0]         in_base_blue,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_was_drawn,
  output logic               out_status
);

  localparam int DEPTH  = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic signed [CW-1:0] W_S = CW'(CANVAS_WIDTH);
  localparam logic signed [CW-1:0] H_S = CW'(CANVAS_HEIGHT);

  seq_state_t state_r, state_nxt;

  // command payload
  logic [3:0]         kind_r;
  logic signed [15:0] a_r, b_r, c_r, d_r;
  logic [23:0]        base_r;
  logic [23:0]        pen_r, pen_nxt;

  // result being built and the output register
  logic [23:0] res_rgb_r, res_rgb_nxt;
  logic        res_drawn_r, res_drawn_nxt;
  logic        res_status_r, res_status_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [23:0] out_rgb_r, out_rgb_nxt;
  logic        out_drawn_r, out_drawn_nxt;
  logic        out_status_r, out_status_nxt;

  logic [1:0]        sub_r, sub_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_cmd_r, clr_cmd_nxt;

  // line stepping
  logic        lx_neg_r, lx_neg_nxt, ly_neg_r, ly_neg_nxt;
  logic [16:0] adx_r, adx_nxt, ady_r, ady_nxt, n_r, n_nxt, li_r, li_nxt;
  logic [17:0] remx_r, remx_nxt, remy_r, remy_nxt, remx_s, remy_s;
  logic [16:0] qx_r, qx_nxt, qy_r, qy_nxt;

  // filled rectangle rows
  logic signed [CW-1:0] row_r, row_nxt, rend_r, rend_nxt;

  // circle
  logic [29:0]        rsq_r, rsq_nxt, isq_r, isq_nxt, v_k;
  logic signed [16:0] k_r, k_nxt, i_r, i_nxt, iabs;
  logic [15:0]        j_r, j_nxt;

  // coordinate views
  logic signed [CW-1:0] ax, by, cw, dh, iw, jw, lx, ly, dxw, dyw;

  // units
  span_t             span_cmd;
  logic              span_go, span_idle, sp_we;
  logic [ADDR_W-1:0] sp_waddr;
  logic [24:0]       sp_wdata;
  logic              sq_start, sq_done;
  logic [31:0]       sq_val;
  logic [15:0]       sq_root;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [24:0]       ram_wdata, ram_rdata;
  logic              ovl_in;

  always_comb begin
    ax   = CW'(a_r);
    by   = CW'(b_r);
    cw   = CW'(c_r);
    dh   = CW'(d_r);
    iw   = CW'(i_r);
    jw   = CW'(j_r);
    lx   = ax + (lx_neg_r ? -CW'(qx_r) : CW'(qx_r));
    ly   = by + (ly_neg_r ? -CW'(qy_r) : CW'(qy_r));
    dxw  = cw - ax;
    dyw  = dh - by;
    iabs = (i_r < 0) ? -i_r : i_r;
    v_k  = 30'((31'(rsq_r) + 31'd1) >> 1);
    remx_s = remx_r + 18'(adx_r);
    remy_s = remy_r + 18'(ady_r);
  end

  // overlay pixel position test and read address
  assign ovl_in    = (a_r >= 0) && (ax < W_S) && (b_r >= 0) && (by < H_S);
  assign ram_raddr = ADDR_W'(ADDR_W'(b_r) * ADDR_W'(CANVAS_WIDTH) + ADDR_W'(a_r));

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    pen_nxt        = pen_r;
    res_rgb_nxt    = res_rgb_r;
    res_drawn_nxt  = res_drawn_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_rgb_nxt    = out_rgb_r;
    out_drawn_nxt  = out_drawn_r;
    out_status_nxt = out_status_r;
    sub_nxt        = sub_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_cmd_nxt    = clr_cmd_r;
    lx_neg_nxt     = lx_neg_r;
    ly_neg_nxt     = ly_neg_r;
    adx_nxt        = adx_r;
    ady_nxt        = ady_r;
    n_nxt          = n_r;
    li_nxt         = li_r;
    remx_nxt       = remx_r;
    remy_nxt       = remy_r;
    qx_nxt         = qx_r;
    qy_nxt         = qy_r;
    row_nxt        = row_r;
    rend_nxt       = rend_r;
    rsq_nxt        = rsq_r;
    isq_nxt        = isq_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    span_go        = 1'b0;
    span_cmd       = '0;
    sq_start       = 1'b0;
    sq_val         = '0;
    ram_re         = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = clr_cmd_r ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        res_rgb_nxt    = '0;
        res_drawn_nxt  = 1'b0;
        res_status_nxt = 1'b0;
        sub_nxt        = '0;
        if (in_valid) begin
          case (in_kind)
            K_POINT: state_nxt = S_POINT;
            K_LINE:  state_nxt = S_LSET;
            K_RECT: begin
              res_status_nxt = (in_arg_c < 0) || (in_arg_d < 0);
              state_nxt      = res_status_nxt ? S_RESP : S_RECT;
            end
            K_RFILL: begin
              res_status_nxt = (in_arg_c < 0) || (in_arg_d < 0);
              state_nxt      = res_status_nxt ? S_RESP : S_RFSET;
            end
            K_CIRC, K_CFILL: begin
              res_status_nxt = (in_arg_c < 0);
              state_nxt      = res_status_nxt ? S_RESP : S_CSQ;
            end
            K_COLOR: begin
              res_status_nxt = (in_arg_a[15:8] != 8'd0) || (in_arg_b[15:8] != 8'd0)
                            || (in_arg_c[15:8] != 8'd0);
              if (!res_status_nxt) begin
                pen_nxt = {in_arg_a[7:0], in_arg_b[7:0], in_arg_c[7:0]};
              end
              state_nxt = S_RESP;
            end
            K_CLEAR: begin
              clr_cnt_nxt = '0;
              clr_cmd_nxt = 1'b1;
              state_nxt   = S_CLEAR;
            end
            K_OVL: state_nxt = S_OVL;
            default: begin
              res_status_nxt = 1'b1;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_POINT: begin
        if (span_idle) begin
          span_go  = 1'b1;
          span_cmd = '{horiz: 1'b1, fixed: by, lo: ax, hi: ax};
          state_nxt = S_WAIT;
        end
      end
      S_LSET: begin
        lx_neg_nxt = (dxw < 0);
        ly_neg_nxt = (dyw < 0);
        adx_nxt    = (dxw < 0) ? 17'(-dxw) : 17'(dxw);
        ady_nxt    = (dyw < 0) ? 17'(-dyw) : 17'(dyw);
        n_nxt      = (adx_nxt > ady_nxt) ? adx_nxt : ady_nxt;
        li_nxt     = '0;
        remx_nxt   = '0;
        remy_nxt   = '0;
        qx_nxt     = '0;
        qy_nxt     = '0;
        state_nxt  = S_LINE;
      end
      S_LINE: begin
        if (span_idle) begin
          span_go  = 1'b1;
          span_cmd = '{horiz: 1'b1, fixed: ly, lo: lx, hi: lx};
          if (li_r == n_r) begin
            state_nxt = S_WAIT;
          end else begin
            li_nxt = li_r + 1'b1;
            if (remx_s >= 18'(n_r)) begin
              remx_nxt = remx_s - 18'(n_r);
              qx_nxt   = qx_r + 1'b1;
            end else begin
              remx_nxt = remx_s;
            end
            if (remy_s >= 18'(n_r)) begin
              remy_nxt = remy_s - 18'(n_r);
              qy_nxt   = qy_r + 1'b1;
            end else begin
              remy_nxt = remy_s;
            end
          end
        end
      end
      S_RECT: begin
        if (span_idle) begin
          span_go = 1'b1;
          case (sub_r)
            2'd0:    span_cmd = '{horiz: 1'b1, fixed: by, lo: ax, hi: ax + cw};
            2'd1:    span_cmd = '{horiz: 1'b1, fixed: by + dh, lo: ax, hi: ax + cw};
            2'd2:    span_cmd = '{horiz: 1'b0, fixed: ax, lo: by, hi: by + dh};
            default: span_cmd = '{horiz: 1'b0, fixed: ax + cw, lo: by, hi: by + dh};
          endcase
          sub_nxt = sub_r + 1'b1;
          if (sub_r == 2'd3) begin
            state_nxt = S_WAIT;
          end
        end
      end
      S_RFSET: begin
        row_nxt   = (by < 0) ? '0 : by;
        rend_nxt  = (by + dh > H_S - 1) ? H_S - 1 : by + dh;
        state_nxt = (row_nxt > rend_nxt) ? S_RESP : S_RFILL;
      end
      S_RFILL: begin
        if (span_idle) begin
          span_go  = 1'b1;
          span_cmd = '{horiz: 1'b1, fixed: row_r, lo: ax, hi: ax + cw};
          if (row_r == rend_r) begin
            state_nxt = S_WAIT;
          end else begin
            row_nxt = row_r + 1'b1;
          end
        end
      end
      S_CSQ: begin
        rsq_nxt   = 30'(c_r[14:0]) * 30'(c_r[14:0]);
        state_nxt = S_CKGO;
      end
      S_CKGO: begin
        if (v_k == 30'd0) begin
          k_nxt     = '0;
          i_nxt     = '0;
          state_nxt = S_CI;
        end else begin
          sq_start  = 1'b1;
          sq_val    = 32'(v_k - 30'd1);
          state_nxt = S_CKW;
        end
      end
      S_CKW: begin
        if (sq_done) begin
          k_nxt     = 17'(sq_root) + 17'sd1;
          i_nxt     = -(17'(sq_root) + 17'sd1);
          state_nxt = S_CI;
        end
      end
      S_CI: begin
        isq_nxt   = 30'(iabs[14:0]) * 30'(iabs[14:0]);
        state_nxt = S_CJGO;
      end
      S_CJGO: begin
        sq_start  = 1'b1;
        sq_val    = 32'(rsq_r - isq_r);
        state_nxt = S_CJW;
      end
      S_CJW: begin
        if (sq_done) begin
          j_nxt     = sq_root;
          sub_nxt   = '0;
          state_nxt = S_COUT;
        end
      end
      S_COUT: begin
        if (span_idle) begin
          span_go = 1'b1;
          if (kind_r == K_CFILL) begin
            if (sub_r == 2'd0) begin
              span_cmd = '{horiz: 1'b0, fixed: ax + iw, lo: by - jw, hi: by + jw};
            end else begin
              span_cmd = '{horiz: 1'b1, fixed: by + iw, lo: ax - jw, hi: ax + jw};
            end
          end else begin
            case (sub_r)
              2'd0:    span_cmd = '{horiz: 1'b1, fixed: by + jw, lo: ax + iw, hi: ax + iw};
              2'd1:    span_cmd = '{horiz: 1'b1, fixed: by - jw, lo: ax + iw, hi: ax + iw};
              2'd2:    span_cmd = '{horiz: 1'b1, fixed: by + iw, lo: ax + jw, hi: ax + jw};
              default: span_cmd = '{horiz: 1'b1, fixed: by + iw, lo: ax - jw, hi: ax - jw};
            endcase
          end
          sub_nxt = sub_r + 1'b1;
          if ((kind_r == K_CFILL && sub_r == 2'd1) || sub_r == 2'd3) begin
            sub_nxt = '0;
            if (i_r == k_r) begin
              state_nxt = S_WAIT;
            end else begin
              i_nxt     = i_r + 17'sd1;
              state_nxt = S_CI;
            end
          end
        end
      end
      S_OVL: begin
        ram_re    = 1'b1;
        state_nxt = S_OVLD;
      end
      S_OVLD: begin
        if (ovl_in && ram_rdata[24]) begin
          res_rgb_nxt   = ram_rdata[23:0];
          res_drawn_nxt = 1'b1;
        end else begin
          res_rgb_nxt = base_r;
        end
        state_nxt = S_RESP;
      end
      S_WAIT: begin
        if (span_idle) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_rgb_nxt    = res_rgb_r;
          out_drawn_nxt  = res_drawn_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      clr_cmd_r   <= 1'b0;
      pen_r       <= '0;
      out_valid_r <= 1'b0;
      sub_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_cmd_r   <= clr_cmd_nxt;
      pen_r       <= pen_nxt;
      out_valid_r <= out_valid_nxt;
      sub_r       <= sub_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      kind_r <= in_kind;
      a_r    <= in_arg_a;
      b_r    <= in_arg_b;
      c_r    <= in_arg_c;
      d_r    <= in_arg_d;
      base_r <= {in_base_red, in_base_green, in_base_blue};
    end
    res_rgb_r    <= res_rgb_nxt;
    res_drawn_r  <= res_drawn_nxt;
    res_status_r <= res_status_nxt;
    out_rgb_r    <= out_rgb_nxt;
    out_drawn_r  <= out_drawn_nxt;
    out_status_r <= out_status_nxt;
    lx_neg_r     <= lx_neg_nxt;
    ly_neg_r     <= ly_neg_nxt;
    adx_r        <= adx_nxt;
    ady_r        <= ady_nxt;
    n_r          <= n_nxt;
    li_r         <= li_nxt;
    remx_r       <= remx_nxt;
    remy_r       <= remy_nxt;
    qx_r         <= qx_nxt;
    qy_r         <= qy_nxt;
    row_r        <= row_nxt;
    rend_r       <= rend_nxt;
    rsq_r        <= rsq_nxt;
    isq_r        <= isq_nxt;
    k_r          <= k_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
  end

  // memory write port shared by clearing pass and span walker
  always_comb begin
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = CLEAR_WORD;
    end else begin
      ram_we    = sp_we;
      ram_waddr = sp_waddr;
      ram_wdata = sp_wdata;
    end
  end

  csr_span #(
    .CANVAS_WIDTH (CANVAS_WIDTH),
    .CANVAS_HEIGHT(CANVAS_HEIGHT),
    .ADDR_W       (ADDR_W)
  ) u_span (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (span_go),
    .cmd    (span_cmd),
    .pen    (pen_r),
    .idle   (span_idle),
    .wr_en  (sp_we),
    .wr_addr(sp_waddr),
    .wr_data(sp_wdata)
  );

  csr_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .val  (sq_val),
    .done (sq_done),
    .root (sq_root)
  );

  csr_ram #(
    .WIDTH (25),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_canvas (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_red       = out_rgb_r[23:16];
  assign out_green     = out_rgb_r[15:8];
  assign out_blue      = out_rgb_r[7:0];
  assign out_was_drawn = out_drawn_r;
  assign out_status    = out_status_r;

endmodule

>>> sv/csr_checker.sv
// port level checks of the shape rasterizer and their binding
`timescale 1ns / 1ps
`include "canvas_shape_rasterizer_unit_defines.svh"
module csr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_was_drawn,
  input logic       out_status
);

  // a stalled result beat holds its payload
  `CSR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(out_status))

  // one command at a time: an accepted beat makes the block busy
  `CSR_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready)

  // a drawn overlay pixel is never a rejected command
  `CSR_ASSERT(a_drawn_ok, out_valid && out_was_drawn |-> !out_status)

  // reset starts the clearing pass, no input taken
  `CSR_ASSERT_RST(a_reset_clears, !rst_n |=> !in_ready)

endmodule

bind canvas_shape_rasterizer_unit csr_checker u_csr_checker (.*);
